>>> hdl/xwh_pkg.sv
package xwh_pkg;

  localparam int unsigned MIX_SHIFT_A = 12;
  localparam int unsigned MIX_SHIFT_B = 47;
  localparam int unsigned MIX_SHIFT_C = 25;
  localparam int unsigned TAIL_BYTES  = 7;
  localparam int unsigned TAIL_W      = 8 * TAIL_BYTES;

  localparam logic [2:0] LAST_POS = 3'(TAIL_BYTES);

  localparam logic CFG_HASH_SEED  = 1'b0;
  localparam logic CFG_BIG_ENDIAN = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;
  } xwh_item_t;

  function automatic logic [63:0] xwh_mix(input logic [63:0] v);
    logic [63:0] a;
    logic [63:0] b;
    a = v ^ (v << MIX_SHIFT_A);
    b = a ^ (a >> MIX_SHIFT_B);
    return b ^ (b << MIX_SHIFT_C);
  endfunction

  function automatic logic [63:0] xwh_swap(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

>>> hdl/xwh_step.sv
module xwh_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_wdata,
  input  logic              fire,
  input  xwh_pkg::xwh_item_t item,
  output logic              has_result,
  output logic [63:0]       hash
);
  import xwh_pkg::*;

  logic [63:0] seed_r;
  logic        be_r;
  logic [63:0] acc_r, acc_nxt;
  logic [TAIL_W-1:0] buf_r, buf_nxt;
  logic [2:0]  pos_r, pos_nxt;

  logic              full;
  logic [63:0]       word;
  logic [63:0]       word_o;
  logic [63:0]       acc_upd;
  logic [TAIL_W-1:0] buf_upd;
  logic [2:0]        pos_upd;

  always_comb begin
    full    = (pos_r == LAST_POS);
    word    = {item.data_byte, buf_r};
    word_o  = be_r ? xwh_swap(word) : word;
    acc_upd = full ? (acc_r ^ xwh_mix(word_o)) : acc_r;
    buf_upd = full ? '0
                   : (buf_r | ({{(TAIL_W-8){1'b0}}, item.data_byte} << {pos_r, 3'b000}));
    pos_upd = full ? 3'd0 : pos_r + 3'd1;

    has_result = item.empty_message | item.last_byte;
    hash = item.empty_message ? xwh_mix(seed_r)
                              : xwh_mix(acc_upd ^ {8'h00, buf_upd});

    acc_nxt = acc_r;
    buf_nxt = buf_r;
    pos_nxt = pos_r;
    if (cfg_wr_en && cfg_index == CFG_HASH_SEED) begin
      acc_nxt = cfg_wdata;
      buf_nxt = '0;
      pos_nxt = 3'd0;
    end else if (fire) begin
      if (has_result) begin
        // rearm for the next message
        acc_nxt = seed_r;
        buf_nxt = '0;
        pos_nxt = 3'd0;
      end else begin
        acc_nxt = acc_upd;
        buf_nxt = buf_upd;
        pos_nxt = pos_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      be_r   <= 1'b0;
      acc_r  <= '0;
      buf_r  <= '0;
      pos_r  <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_HASH_SEED:  seed_r <= cfg_wdata;
          CFG_BIG_ENDIAN: be_r   <= cfg_wdata[0];
        endcase
      end
      acc_r <= acc_nxt;
      buf_r <= buf_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> hdl/xorshift_word_hash64.sv
// Byte-serial xorshift word hash, 64-bit result.
// A final byte is held in the input register; its hash is then registered for out_*.
// Throughput: one byte per cycle; the input register and result register decouple
// the two sides, so a waiting hash stalls only words that end a message.
// Reset (rst_n low, synchronous): seed and byte order cleared, message state
// cleared, both pipeline registers empty.
module xorshift_word_hash64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);
  import xwh_pkg::*;

  xwh_item_t   item_r;
  logic        in_valid_r;
  logic        out_valid_r;
  logic [63:0] out_hash_value_r;

  logic        has_result;
  logic [63:0] hash;
  logic        consume;

  xwh_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fire       (consume),
    .item       (item_r),
    .has_result (has_result),
    .hash       (hash)
  );

  // a word that ends no message never needs the result register
  assign consume  = in_valid_r & (~has_result | ~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | consume;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (consume && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.data_byte     <= in_data_byte;
      item_r.last_byte     <= in_last_byte;
      item_r.empty_message <= in_empty_message;
    end
    if (consume && has_result) begin
      out_hash_value_r <= hash;
    end
  end

endmodule

>>> tb/tb_xorshift_word_hash64.sv
module tb_xorshift_word_hash64;
  import xwh_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 170;
  localparam int PRESSURE_HOLD = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        in_empty_message;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_hash_value;

  int errors;
  int hold_cycles;
  bit source_idle;
  bit sink_idle;

  class hash_predictor;
    bit [63:0] seed;
    bit        big_endian;
    bit [63:0] accum;
    bit [55:0] word_buf;
    bit [2:0]  fill;
    bit [63:0] expected_hashes[$];

    function new();
      seed       = '0;
      big_endian = 1'b0;
      rearm();
    endfunction

    function void rearm();
      accum    = seed;
      word_buf = '0;
      fill     = '0;
    endfunction

    function bit [63:0] scramble(bit [63:0] v);
      bit [63:0] t;
      t = v ^ (v << MIX_SHIFT_A);
      t = t ^ (t >> MIX_SHIFT_B);
      t = t ^ (t << MIX_SHIFT_C);
      return t;
    endfunction

    function bit [63:0] reverse_bytes(bit [63:0] w);
      bit [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
        r = (r << 8) | {56'h0, w[7:0]};
        w = w >> 8;
      end
      return r;
    endfunction

    // seed write also drops any partial message
    function void load_seed(bit [63:0] value);
      seed = value;
      rearm();
    endfunction

    function void set_big_endian(bit value);
      big_endian = value;
    endfunction

    function void note_word(bit [7:0] b, bit last, bit empty);
      bit [63:0] w;
      if (empty) begin
        expected_hashes.push_back(scramble(seed));
        rearm();
        return;
      end
      if (fill == 3'(TAIL_BYTES)) begin
        w = {b, word_buf};
        if (big_endian) w = reverse_bytes(w);
        accum    = accum ^ scramble(w);
        word_buf = '0;
        fill     = '0;
      end else begin
        word_buf[8*fill +: 8] = b;
        fill = fill + 3'd1;
      end
      if (last) begin
        // tail bytes go in unmixed, little-endian
        expected_hashes.push_back(scramble(accum ^ {8'h00, word_buf}));
        rearm();
      end
    endfunction

    function bit check_hash(bit [63:0] got, output string why);
      bit [63:0] want;
      if (expected_hashes.size() == 0) begin
        why = $sformatf("unexpected hash %016h", got);
        return 1'b0;
      end
      want = expected_hashes.pop_front();
      if (got !== want) begin
        why = $sformatf("hash_value got %016h want %016h", got, want);
        return 1'b0;
      end
      why = "";
      return 1'b1;
    endfunction

    function int outstanding();
      return expected_hashes.size();
    endfunction
  endclass

  hash_predictor hashes = new();

  xorshift_word_hash64 DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_empty_message(in_empty_message),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH: %s", what);
  endtask

  task automatic cfg_write(logic idx, logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_HASH_SEED) hashes.load_seed(value);
    else hashes.set_big_endian(value[0]);
  endtask

  task automatic send_word(logic [7:0] b, logic last, logic empty);
    int gap;
    gap = source_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_last_byte     <= last;
    in_empty_message <= empty;
    do @(posedge clk); while (!in_ready);
    hashes.note_word(b, last, empty);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(8'($urandom), i == len - 1, 1'b0);
  endtask

  // hold input, wait for all hashes, then let bytes still in flight settle
  task automatic drain();
    in_valid <= 1'b0;
    while (hashes.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_word(8'($urandom), 1'($urandom), 1'b1);
        sent++;
      end else if (kind == 1) begin
        // noise: stray bytes with random last flags
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          send_word(8'($urandom), $urandom_range(0, 3) == 0, 1'b0);
        sent += len;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        send_message(len);
        sent += len;
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    string why;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      gap = 0;
      if (out_valid && out_ready) begin
        if (!hashes.check_hash(out_hash_value, why)) report_mismatch(why);
        if (sink_idle) gap = $urandom_range(0, 7);
      end
      if (hold_cycles != 0) begin
        gap += hold_cycles;
        hold_cycles = 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit [63:0] seed;
    bit        order;
    errors      = 0;
    hold_cycles = 0;
    source_idle = 1'b1;
    sink_idle   = 1'b1;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= CFG_HASH_SEED;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_last_byte     <= 1'b0;
    in_empty_message <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero seed, little-endian
    send_word(8'h5A, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h12, 1'b0, 1'b0);
    send_word(8'hAA, 1'b1, 1'b1);
    drain();

    // all-ones seed, big-endian: one full word plus one tail byte
    cfg_write(CFG_BIG_ENDIAN, 64'd1);
    cfg_write(CFG_HASH_SEED, '1);
    for (int i = 0; i < 9; i++) send_word(8'(8'hF8 + i), i == 8, 1'b0);

    // flip byte order while a word is half packed
    for (int i = 0; i < 5; i++) send_word(8'(i * 8'h33), 1'b0, 1'b0);
    drain();
    cfg_write(CFG_BIG_ENDIAN, 64'd0);
    for (int i = 0; i < 4; i++) send_word(8'(8'hC0 | i), i == 3, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      seed  = (p == 0) ? 64'h0 : (p == 1) ? '1 : {$urandom, $urandom};
      order = (p < 2) ? 1'(p) : 1'($urandom_range(0, 1));
      if (p % 2 == 0) cfg_write(CFG_BIG_ENDIAN, {63'h0, order});
      if (p < 4 || $urandom_range(0, 2) != 0) cfg_write(CFG_HASH_SEED, seed);
      if (p % 2 == 1) cfg_write(CFG_BIG_ENDIAN, {63'h0, order});
      source_idle = $urandom_range(0, 2) != 0;
      sink_idle   = $urandom_range(0, 2) != 0;
      if (p == 2) begin
        source_idle = 1'b0;
        sink_idle   = 1'b0;
      end
      if (p == 3) begin
        // stall the result side while bytes keep coming
        source_idle = 1'b0;
        hold_cycles = PRESSURE_HOLD;
      end
      random_phase(PHASE_WORDS);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/xwh_pkg.sv
hdl/xwh_step.sv
hdl/xorshift_word_hash64.sv
tb/tb_xorshift_word_hash64.sv
